### hdl/isochrone_mass_interpolator_defines.svh
// Assertion macros for the isochrone mass interpolator checker.
// Depends on nothing; included by the checker file.
`ifndef ISOCHRONE_MASS_INTERPOLATOR_DEFINES_SVH
`define ISOCHRONE_MASS_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISMI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ismi_pkg.sv
// Shared types and constants of the isochrone mass interpolator.
// Depends on nothing; imported by every module of the block.
package ismi_pkg;

   localparam int DEF_MAX_POINTS  = 256;
   localparam int DEF_MAX_FILTERS = 8;
   localparam int RESULT_LIMIT    = 8;

   localparam int MASS_W = 27;
   localparam int MAG_W  = 27;
   localparam int PROD_W = 56;
   localparam int NUM_W  = 58;
   localparam int MUL_STEPS = 28;
   localparam int DIV_STEPS = 58;

   localparam logic signed [MAG_W-1:0] MAG_MAX  = 27'sd67108863;
   localparam logic signed [MAG_W-1:0] MAG_MIN  = -27'sd67108864;
   localparam logic signed [MAG_W-1:0] SENTINEL = 27'sd65535345;

   localparam logic [1:0] CSR_ENTRIES_USED = 2'd0;
   localparam logic [1:0] CSR_FILTERS_USED = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic signed [MAG_W-1:0] m0;
      logic signed [MAG_W-1:0] m1;
      logic [MASS_W-1:0]       q;
      logic [MASS_W-1:0]       x0;
      logic [MASS_W-1:0]       x1;
   } operand_type;

endpackage

### hdl/ismi_tables.sv
// Mass table and magnitude table with one write port and two registered read ports.
// Depends on ismi_pkg.
module ismi_tables #(
   parameter int MAX_POINTS  = ismi_pkg::DEF_MAX_POINTS,
   parameter int MAX_FILTERS = ismi_pkg::DEF_MAX_FILTERS,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_point,
   input  logic [FW-1:0]                        wr_filter,
   input  logic [ismi_pkg::MASS_W-1:0]          wr_mass,
   input  logic signed [ismi_pkg::MAG_W-1:0]    wr_mag,
   input  logic [AW-1:0]                        rd_point_a,
   input  logic [AW-1:0]                        rd_point_b,
   input  logic [FW-1:0]                        rd_filter,
   output logic [ismi_pkg::MASS_W-1:0]          mass_a,
   output logic [ismi_pkg::MASS_W-1:0]          mass_b,
   output logic signed [ismi_pkg::MAG_W-1:0]    mag_a,
   output logic signed [ismi_pkg::MAG_W-1:0]    mag_b
);
   import ismi_pkg::*;

   logic [MASS_W-1:0] mass_mem [MAX_POINTS];
   logic [MAG_W-1:0]  mag_mem  [MAX_POINTS * (2 ** FW)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mass_mem[wr_point] <= wr_mass;
         mag_mem[{wr_point, wr_filter}] <= wr_mag;
      end
      mass_a <= mass_mem[rd_point_a];
      mass_b <= mass_mem[rd_point_b];
      mag_a  <= mag_mem[{rd_point_a, rd_filter}];
      mag_b  <= mag_mem[{rd_point_b, rd_filter}];
   end

endmodule

### hdl/ismi_muldiv.sv
// Shared shift-add multiplier and restoring divider for one interpolation.
// Depends on ismi_pkg.
module ismi_muldiv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  ismi_pkg::operand_type              oper,
   input  logic [15:0]                        threshold,
   output logic                               done,
   output logic signed [ismi_pkg::MAG_W-1:0]  result
);
   import ismi_pkg::*;

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_MUL  = 5'b00010,
      U_PREP = 5'b00100,
      U_DIV  = 5'b01000,
      U_FIN  = 5'b10000
   } unit_state_type;

   unit_state_type      state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [MAG_W-1:0]    m0_ff, m0_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic [27:0]         d_ff, d_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [27:0]         mplier_ff, mplier_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [28:0]         rem_ff, rem_in;
   logic [MAG_W-1:0]    result_ff, result_in;

   logic [27:0]         dm, dq, dx, abs_dm, abs_dq, abs_dx;
   logic [29:0]         shifted, dvsr;
   logic                ge;
   logic [59:0]         m0_x, q_x, sum_v;
   logic [MAG_W-1:0]    sat, mag_abs;

   always_comb begin
      dm = {oper.m1[MAG_W-1], oper.m1} - {oper.m0[MAG_W-1], oper.m0};
      dq = {1'b0, oper.q} - {1'b0, oper.x0};
      dx = {1'b0, oper.x1} - {1'b0, oper.x0};
      abs_dm = dm[27] ? (~dm + 28'd1) : dm;
      abs_dq = dq[27] ? (~dq + 28'd1) : dq;
      abs_dx = dx[27] ? (~dx + 28'd1) : dx;

      shifted = {rem_ff, num_ff[NUM_W-1]};
      dvsr    = {1'b0, d_ff, 1'b0};
      ge      = (shifted >= dvsr);

      m0_x  = {{(60-MAG_W){m0_ff[MAG_W-1]}}, m0_ff};
      q_x   = {2'b00, num_ff};
      sum_v = zero_ff ? m0_x : (m0_x + (neg_ff ? (~q_x + 60'd1) : q_x));
      if ($signed(sum_v) > 60'(MAG_MAX)) begin
         sat = MAG_MAX;
      end else if ($signed(sum_v) < 60'(MAG_MIN)) begin
         sat = MAG_MIN;
      end else begin
         sat = sum_v[MAG_W-1:0];
      end
      mag_abs = sat[MAG_W-1] ? (~sat + 27'd1) : sat;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      m0_in     = m0_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      d_in      = d_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      result_in = result_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               m0_in     = oper.m0;
               neg_in    = dm[27] ^ dq[27] ^ dx[27];
               zero_in   = (dx == 28'd0);
               d_in      = abs_dx;
               mcand_in  = {28'd0, abs_dm};
               mplier_in = abs_dq;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = U_MUL;
            end
         end
         U_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[27:1]};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               state_in = U_PREP;
            end
         end
         U_PREP: begin
            num_in   = {1'b0, acc_ff, 1'b0} + {30'd0, d_ff};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in = ge ? 29'(shifted - dvsr) : shifted[28:0];
            num_in = {num_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            result_in = (mag_abs < {11'd0, threshold}) ? SENTINEL : sat;
            done_in   = 1'b1;
            state_in  = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      m0_ff     <= m0_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      d_ff      <= d_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### hdl/isochrone_mass_interpolator.sv
// Isochrone mass interpolator. A load transaction returns nothing.
// A query runs a binary search over the mass table, each probe a table read and a compare
// (up to floor(log2(n))+1 probes, one memory read each, n being the entries in use clamped
// to 2..MAX_POINTS), then per filter in use a shift-add multiply and a restoring divide
// in one shared unit, plus table fetch, rounding and saturation. Results come out one per
// filter in order; each waits in the output register until taken, and the next
// filter starts after it. No new transaction is taken until the last result is taken.
// Depends on ismi_pkg, ismi_tables and ismi_muldiv.
module isochrone_mass_interpolator #(
   parameter int MAX_POINTS  = ismi_pkg::DEF_MAX_POINTS,
   parameter int MAX_FILTERS = ismi_pkg::DEF_MAX_FILTERS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [1:0]                         csr_index,
   input  logic [15:0]                        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [7:0]                         req_entry_index,
   input  logic [2:0]                         req_filter_index,
   input  logic [ismi_pkg::MASS_W-1:0]        req_entry_mass,
   input  logic signed [ismi_pkg::MAG_W-1:0]  req_entry_magnitude,
   input  logic [ismi_pkg::MASS_W-1:0]        req_query_mass,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_out_filter,
   output logic signed [ismi_pkg::MAG_W-1:0]  rsp_magnitude,
   output logic                               rsp_last
);
   import ismi_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int NF_MAX = (MAX_FILTERS < RESULT_LIMIT) ? MAX_FILTERS : RESULT_LIMIT;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SRCH_RD  = 8'b0000_0010,
      ST_SRCH_CMP = 8'b0000_0100,
      ST_ADJUST   = 8'b0000_1000,
      ST_FETCH    = 8'b0001_0000,
      ST_START    = 8'b0010_0000,
      ST_WAIT     = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [8:0]         entries_ff;
   logic [3:0]         filters_ff;
   logic [15:0]        thresh_ff;
   logic [MASS_W-1:0]  q_ff, q_in;
   logic [NW-1:0]      lo_ff, lo_in, count_ff, count_in;
   logic [2:0]         k_ff, k_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;

   logic [NW-1:0]      n_val, step, probe;
   logic [3:0]         nf;
   logic               req_fire, rsp_fire, load_en, last_k;
   logic [AW-1:0]      addr_a, addr_b;
   logic [MASS_W-1:0]  mass_a, mass_b;
   logic [MAG_W-1:0]   mag_a, mag_b;
   operand_type        oper;
   logic               unit_done;
   logic [MAG_W-1:0]   unit_result;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign load_en  = req_fire && (req_kind == KIND_LOAD)
                     && (32'(req_entry_index) < MAX_POINTS)
                     && (32'(req_filter_index) < MAX_FILTERS);

   always_comb begin
      if (entries_ff < 9'd2) begin
         n_val = NW'(2);
      end else if (32'(entries_ff) > MAX_POINTS) begin
         n_val = NW'(MAX_POINTS);
      end else begin
         n_val = NW'(entries_ff);
      end
      if (filters_ff == 4'd0) begin
         nf = 4'd1;
      end else if (32'(filters_ff) > NF_MAX) begin
         nf = 4'(NF_MAX);
      end else begin
         nf = filters_ff;
      end
      step   = count_ff >> 1;
      probe  = lo_ff + step;
      addr_a = (state_ff == ST_FETCH) ? AW'(lo_ff) : AW'(probe);
      addr_b = AW'(lo_ff + NW'(1));
      last_k = ({1'b0, k_ff} + 4'd1) == nf;
      oper.m0 = mag_a;
      oper.m1 = mag_b;
      oper.q  = q_ff;
      oper.x0 = mass_a;
      oper.x1 = mass_b;
   end

   ismi_tables #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_FILTERS(MAX_FILTERS)
   ) u_tables (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_point  (AW'(req_entry_index)),
      .wr_filter (FW'(req_filter_index)),
      .wr_mass   (req_entry_mass),
      .wr_mag    (req_entry_magnitude),
      .rd_point_a(addr_a),
      .rd_point_b(addr_b),
      .rd_filter (FW'(k_ff)),
      .mass_a    (mass_a),
      .mass_b    (mass_b),
      .mag_a     (mag_a),
      .mag_b     (mag_b)
   );

   ismi_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .oper     (oper),
      .threshold(thresh_ff),
      .done     (unit_done),
      .result   (unit_result)
   );

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      lo_in    = lo_ff;
      count_in = count_ff;
      k_in     = k_ff;
      mag_in   = mag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_QUERY)) begin
               q_in     = req_query_mass;
               lo_in    = '0;
               count_in = n_val;
               k_in     = '0;
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (mass_a < q_ff) begin
               lo_in    = probe + NW'(1);
               count_in = count_ff - step - NW'(1);
            end else begin
               count_in = step;
            end
            state_in = (count_in == '0) ? ST_ADJUST : ST_SRCH_RD;
         end
         ST_ADJUST: begin
            if (lo_ff == n_val) begin
               lo_in = n_val - NW'(2);
            end else if (lo_ff != '0) begin
               lo_in = lo_ff - NW'(1);
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (unit_done) begin
               mag_in   = unit_result;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (last_k) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         entries_ff <= 9'd256;
         filters_ff <= 4'd8;
         thresh_ff  <= 16'd1;
         k_ff       <= '0;
         lo_ff      <= '0;
         count_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         lo_ff    <= lo_in;
         count_ff <= count_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_ENTRIES_USED: entries_ff <= csr_wdata[8:0];
               CSR_FILTERS_USED: filters_ff <= csr_wdata[3:0];
               CSR_THRESHOLD:    thresh_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
      q_ff   <= q_in;
      mag_ff <= mag_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_out_filter = k_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_last       = last_k;

endmodule

### hdl/ismi_checker.sv
// Port-level checker for the isochrone mass interpolator, bound to the top level.
// Depends on isochrone_mass_interpolator_defines.svh and ismi_pkg.
`include "isochrone_mass_interpolator_defines.svh"

module ismi_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_kind,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [2:0]                         rsp_out_filter,
   input logic signed [ismi_pkg::MAG_W-1:0]  rsp_magnitude,
   input logic                               rsp_last
);
   import ismi_pkg::*;

   `ISMI_ASSERT_IMPL(a_busy_while_rsp, clock, reset, rsp_valid, req_stall, "req taken while result pending")
   `ISMI_ASSERT_NEXT(a_query_blocks, clock, reset, req_valid && !req_stall && (req_kind == KIND_QUERY), req_stall && !rsp_valid, "query did not start work")
   `ISMI_ASSERT_NEXT(a_load_idle, clock, reset, req_valid && !req_stall && (req_kind == KIND_LOAD), !req_stall, "load left block busy")
   `ISMI_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last, !rsp_valid && !req_stall, "result after last transaction")
   `ISMI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_magnitude) && $stable(rsp_out_filter), "stalled result changed")

endmodule

bind isochrone_mass_interpolator ismi_checker u_ismi_checker (.*);
